FILE: rtl/core/rgbc_pkg.sv
// Shared types, constants and helper functions for the 5x5 RGB convolution block.
// Used by every module under rtl/core except rgbc_ram; depends on nothing else.

package rgbc_pkg;

  // Default line store depth in pixels (one image row at most this wide).
  localparam int unsigned MAX_WIDTH_DEF = 1024;

  // Mask geometry.
  localparam int unsigned TAPS = 5;
  localparam int unsigned NTAP = TAPS * TAPS;
  localparam int unsigned LINES = TAPS - 1;
  localparam int unsigned NCH = 3;

  // Field widths.
  localparam int unsigned PIX_W = 8;
  localparam int unsigned RGB_W = NCH * PIX_W;
  localparam int unsigned COLUMN_W = LINES * RGB_W;
  localparam int unsigned COEF_W = 12;
  localparam int unsigned COEF_ROW_W = TAPS * COEF_W;
  localparam int unsigned IMG_W_W = 11;
  localparam int unsigned IMG_H_W = 16;
  localparam int unsigned ROW_CNT_W = IMG_H_W + 1;
  localparam int unsigned CFG_IDX_W = 3;

  // Arithmetic widths: 12x9 signed product, five of them, then twenty-five.
  localparam int unsigned PROD_W = 21;
  localparam int unsigned RSUM_W = 24;
  localparam int unsigned SUM_W = 26;
  localparam int unsigned FRAC_W = 10;
  localparam int unsigned ROUND_HALF = 512;

  // Register reset values.
  localparam logic [COEF_ROW_W-1:0] COEF_ROW_RST = '0;
  localparam logic [COEF_ROW_W-1:0] COEF_ROW2_RST = 60'd17179869184;
  localparam logic [IMG_W_W-1:0] IMG_W_RST = 11'd640;
  localparam logic [IMG_H_W-1:0] IMG_H_RST = 16'd480;

  // Input item commands.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF0  = 3'd0,
    REG_COEF1  = 3'd1,
    REG_COEF2  = 3'd2,
    REG_COEF3  = 3'd3,
    REG_COEF4  = 3'd4,
    REG_WIDTH  = 3'd5,
    REG_HEIGHT = 3'd6
  } reg_idx_t;

  // Packed pixel: red in the low byte, blue in the high byte.
  typedef struct packed {
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] r;
  } rgb_t;

  // Per-item control that travels beside a pixel through the window stages.
  typedef struct packed {
    logic            emit;
    logic            last;
    logic [TAPS-1:0] row_ok;
    logic [TAPS-1:0] col_ok;
  } item_ctl_t;

  function automatic logic signed [COEF_W-1:0] tap_of(input logic [COEF_ROW_W-1:0] row,
                                                      input int unsigned j);
    tap_of = $signed(row[COEF_W*j +: COEF_W]);
  endfunction

  function automatic logic [PIX_W-1:0] chan_of(input rgb_t p, input int unsigned k);
    case (k)
      0: chan_of = p.r;
      1: chan_of = p.g;
      default: chan_of = p.b;
    endcase
  endfunction

  // Round half up, drop the fraction and saturate to 0..255.
  function automatic logic [PIX_W-1:0] finish_sum(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] r;
    r = s + SUM_W'(ROUND_HALF);
    if (r[SUM_W-1]) begin
      finish_sum = '0;
    end else if (|r[SUM_W-2:FRAC_W+PIX_W]) begin
      finish_sum = '1;
    end else begin
      finish_sum = r[FRAC_W+PIX_W-1:FRAC_W];
    end
  endfunction

endpackage

FILE: rtl/core/rgbc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the line store.

module rgbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/rgbc_ctrl.sv
// Frame sequencer: input and output position counters, frame size latch and
// the per-item emit, last and border decisions. Depends on rgbc_pkg.

module rgbc_ctrl #(
  parameter int unsigned MAX_WIDTH = rgbc_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic                                command,
  input  rgbc_pkg::rgb_t                      pix,
  input  logic [rgbc_pkg::IMG_W_W-1:0]        image_width,
  input  logic [rgbc_pkg::IMG_H_W-1:0]        image_height,
  output logic                                keep,
  output logic [$clog2(MAX_WIDTH)-1:0]        addr,
  output rgbc_pkg::rgb_t                      pix_store,
  output rgbc_pkg::item_ctl_t                 ctl
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned FW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMPW = (FW > rgbc_pkg::IMG_W_W) ? FW : rgbc_pkg::IMG_W_W;
  localparam int unsigned PREW = FW + 2;
  localparam int unsigned YW = rgbc_pkg::IMG_H_W + 2;
  localparam int unsigned XW = FW + 2;
  localparam int unsigned TAPS_W = rgbc_pkg::TAPS;

  logic                          active;
  logic [FW-1:0]                 frame_w;
  logic [rgbc_pkg::IMG_H_W-1:0]  frame_h;
  logic [CW-1:0]                 in_column;
  logic [rgbc_pkg::ROW_CNT_W-1:0] in_row;
  logic [PREW-1:0]               pre_cnt;
  logic [CW-1:0]                 out_col;
  logic [rgbc_pkg::IMG_H_W-1:0]  out_row;

  logic [FW-1:0]                 w_clamp;
  logic [rgbc_pkg::IMG_H_W-1:0]  h_clamp;
  logic [FW-1:0]                 w_cur;
  logic [rgbc_pkg::IMG_H_W-1:0]  h_cur;
  logic                          emit;
  logic                          last;
  logic                          in_frame;
  logic                          in_wrap;
  logic                          out_wrap;
  logic [TAPS_W-1:0]             row_ok;
  logic [TAPS_W-1:0]             col_ok;

  always_comb begin
    if (image_width == '0) begin
      w_clamp = FW'(1);
    end else if (CMPW'(image_width) > CMPW'(MAX_WIDTH)) begin
      w_clamp = FW'(MAX_WIDTH);
    end else begin
      w_clamp = FW'(image_width);
    end
    h_clamp = (image_height == '0) ? rgbc_pkg::IMG_H_W'(1) : image_height;
  end

  // The first pixel of a frame already uses the size it latches.
  assign w_cur = active ? frame_w : w_clamp;
  assign h_cur = active ? frame_h : h_clamp;

  assign keep     = active || (command == rgbc_pkg::CMD_PIXEL);
  assign emit     = (pre_cnt == (PREW'({w_cur, 1'b0}) + PREW'(2)));
  assign in_frame = (in_row < rgbc_pkg::ROW_CNT_W'(h_cur));
  assign last     = emit && (out_row == h_cur - rgbc_pkg::IMG_H_W'(1))
                    && (FW'(out_col) == w_cur - FW'(1));
  assign in_wrap  = ((FW'(in_column) + FW'(1)) == w_cur);
  assign out_wrap = ((FW'(out_col) + FW'(1)) == w_cur);

  always_comb begin
    logic [YW-1:0] y;
    logic [XW-1:0] x;
    for (int i = 0; i < TAPS_W; i++) begin
      y = YW'(out_row) + YW'(i);
      x = XW'(out_col) + XW'(i);
      row_ok[i] = (y >= YW'(2)) && (y < YW'(h_cur) + YW'(2));
      col_ok[i] = (x >= XW'(2)) && (x < XW'(w_cur) + XW'(2));
    end
  end

  assign addr      = in_column;
  assign pix_store = ((command == rgbc_pkg::CMD_PIXEL) && in_frame) ? pix : '0;
  assign ctl       = '{emit: emit, last: last, row_ok: row_ok, col_ok: col_ok};

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      frame_w   <= FW'(1);
      frame_h   <= rgbc_pkg::IMG_H_W'(1);
      in_column <= '0;
      in_row    <= '0;
      pre_cnt   <= '0;
      out_col   <= '0;
      out_row   <= '0;
    end else if (accept && keep) begin
      if (!active) begin
        active  <= 1'b1;
        frame_w <= w_clamp;
        frame_h <= h_clamp;
      end
      if (last) begin
        active    <= 1'b0;
        in_column <= '0;
        in_row    <= '0;
        pre_cnt   <= '0;
        out_col   <= '0;
        out_row   <= '0;
      end else begin
        if (in_wrap) begin
          in_column <= '0;
          in_row    <= in_row + rgbc_pkg::ROW_CNT_W'(1);
        end else begin
          in_column <= in_column + CW'(1);
        end
        if (!emit) begin
          pre_cnt <= pre_cnt + PREW'(1);
        end else if (out_wrap) begin
          out_col <= '0;
          out_row <= out_row + rgbc_pkg::IMG_H_W'(1);
        end else begin
          out_col <= out_col + CW'(1);
        end
      end
    end
  end

endmodule

FILE: rtl/core/rgbc_window.sv
// Line store and 5x5 window: reads the four stored rows of a column, writes
// the shifted column back and shifts the window. Depends on rgbc_pkg, rgbc_ram.

module rgbc_window #(
  parameter int unsigned MAX_WIDTH = rgbc_pkg::MAX_WIDTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       accept,
  input  logic [$clog2(MAX_WIDTH)-1:0]               addr,
  input  rgbc_pkg::rgb_t                             pix,
  input  rgbc_pkg::item_ctl_t                        ctl,
  input  logic                                       next_ready,
  output logic                                       ready,
  output logic                                       win_valid,
  output rgbc_pkg::rgb_t [rgbc_pkg::NTAP-1:0]        win,
  output logic                                       win_last
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned T = rgbc_pkg::TAPS;
  localparam int unsigned RW = rgbc_pkg::RGB_W;
  localparam int unsigned COLW = rgbc_pkg::COLUMN_W;

  // Column stage.
  logic                 v1;
  logic [CW-1:0]        addr1;
  rgbc_pkg::rgb_t       pix1;
  rgbc_pkg::item_ctl_t  ctl1;
  logic                 byp1;
  logic [COLW-1:0]      bypd1;
  logic [COLW-1:0]      rd_data;

  // Window stage.
  logic                 v2;
  rgbc_pkg::rgb_t       win_r [T][T];
  logic [T-1:0]         row_ok2;
  logic [T-1:0]         col_ok2;
  logic                 last2;

  logic                 adv2;
  logic                 fire1;
  logic [COLW-1:0]      col_old;
  logic [COLW-1:0]      wdata;
  rgbc_pkg::rgb_t       col_new [T];

  assign adv2  = !v2 || next_ready;
  assign ready = !v1 || adv2;
  assign fire1 = v1 && adv2;

  // A column written at the same edge as its next read is forwarded.
  assign col_old = byp1 ? bypd1 : rd_data;
  assign wdata   = {col_old[COLW-RW-1:0], pix1};

  always_comb begin
    col_new[T-1] = pix1;
    for (int i = 0; i < T - 1; i++) begin
      col_new[i] = col_old[RW*(T-2-i) +: RW];
    end
  end

  rgbc_ram #(
    .WIDTH (COLW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (fire1),
    .waddr (addr1),
    .wdata (wdata),
    .re    (accept),
    .raddr (addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (ready) begin
        v1 <= accept;
      end
      if (adv2) begin
        v2 <= v1 && ctl1.emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr1 <= addr;
      pix1  <= pix;
      ctl1  <= ctl;
      byp1  <= fire1 && (addr1 == addr);
      bypd1 <= wdata;
    end
    if (fire1) begin
      for (int i = 0; i < T; i++) begin
        for (int j = 0; j < T - 1; j++) begin
          win_r[i][j] <= win_r[i][j+1];
        end
        win_r[i][T-1] <= col_new[i];
      end
      row_ok2 <= ctl1.row_ok;
      col_ok2 <= ctl1.col_ok;
      last2   <= ctl1.last;
    end
  end

  always_comb begin
    for (int i = 0; i < T; i++) begin
      for (int j = 0; j < T; j++) begin
        win[i*T+j] = (row_ok2[i] && col_ok2[j]) ? win_r[i][j] : '0;
      end
    end
  end

  assign win_valid = v2;
  assign win_last  = last2;

endmodule

FILE: rtl/core/rgbc_mac.sv
// Multiply-accumulate pipeline: 75 tap products, row sums, final sum with
// rounding and saturation into the result register. Depends on rgbc_pkg.

module rgbc_mac (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              in_valid,
  input  rgbc_pkg::rgb_t [rgbc_pkg::NTAP-1:0]               win,
  input  logic                                              in_last,
  input  logic [rgbc_pkg::TAPS-1:0][rgbc_pkg::COEF_ROW_W-1:0] coef,
  input  logic                                              stall,
  output logic                                              in_ready,
  output logic                                              out_valid,
  output logic [rgbc_pkg::PIX_W-1:0]                        red,
  output logic [rgbc_pkg::PIX_W-1:0]                        green,
  output logic [rgbc_pkg::PIX_W-1:0]                        blue,
  output logic                                              last
);

  localparam int unsigned T = rgbc_pkg::TAPS;
  localparam int unsigned NT = rgbc_pkg::NTAP;
  localparam int unsigned NC = rgbc_pkg::NCH;
  localparam int unsigned PW = rgbc_pkg::PROD_W;
  localparam int unsigned RSW = rgbc_pkg::RSUM_W;
  localparam int unsigned SW = rgbc_pkg::SUM_W;
  localparam int unsigned CWD = rgbc_pkg::COEF_W;
  localparam int unsigned PXW = rgbc_pkg::PIX_W;

  logic                  v3, v4, v5;
  logic                  adv3, adv4, adv5;
  logic                  last3, last4, last5;
  logic signed [PW-1:0]  prod_next [NC][NT];
  logic signed [PW-1:0]  prod [NC][NT];
  logic signed [RSW-1:0] rs_next [NC][T];
  logic signed [RSW-1:0] rs [NC][T];
  logic [PXW-1:0]        ch_next [NC];
  logic [PXW-1:0]        ch [NC];

  assign adv5     = !v5 || !stall;
  assign adv4     = !v4 || adv5;
  assign adv3     = !v3 || adv4;
  assign in_ready = adv3;

  always_comb begin
    logic signed [CWD-1:0] tv;
    logic signed [PXW:0]   sv;
    for (int k = 0; k < NC; k++) begin
      for (int i = 0; i < T; i++) begin
        for (int j = 0; j < T; j++) begin
          tv = rgbc_pkg::tap_of(coef[i], j);
          sv = $signed({1'b0, rgbc_pkg::chan_of(win[i*T+j], k)});
          prod_next[k][i*T+j] = PW'(tv) * PW'(sv);
        end
      end
    end
  end

  always_comb begin
    logic signed [RSW-1:0] acc;
    for (int k = 0; k < NC; k++) begin
      for (int i = 0; i < T; i++) begin
        acc = '0;
        for (int j = 0; j < T; j++) begin
          acc = acc + RSW'(prod[k][i*T+j]);
        end
        rs_next[k][i] = acc;
      end
    end
  end

  always_comb begin
    logic signed [SW-1:0] tot;
    for (int k = 0; k < NC; k++) begin
      tot = '0;
      for (int i = 0; i < T; i++) begin
        tot = tot + SW'(rs[k][i]);
      end
      ch_next[k] = rgbc_pkg::finish_sum(tot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (adv3) begin
        v3 <= in_valid;
      end
      if (adv4) begin
        v4 <= v3;
      end
      if (adv5) begin
        v5 <= v4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      prod  <= prod_next;
      last3 <= in_last;
    end
    if (adv4) begin
      rs    <= rs_next;
      last4 <= last3;
    end
    if (adv5) begin
      ch    <= ch_next;
      last5 <= last4;
    end
  end

  assign out_valid = v5;
  assign red       = ch[0];
  assign green     = ch[1];
  assign blue      = ch[2];
  assign last      = last5;

endmodule

FILE: rtl/core/rgb_conv2d_5x5_clamped.sv
// Top level of the streaming 5x5 RGB convolution with zero padding and clamping.
// Depends on rgbc_pkg, rgbc_ctrl, rgbc_window, rgbc_mac (and rgbc_ram below them).
//
//   Channel   Handshake                   Payload
//   pixel     pixel_valid / pixel_stall   command, red_in, green_in, blue_in
//   result    result_valid / result_stall red_out, green_out, blue_out, frame_last
//   config    cfg_write (no handshake)    cfg_index, cfg_data
//
// One pixel transaction is accepted per clock while pixel_stall is low. A result
// reaches the result register once the transaction that completes its window has
// passed the line store read, the window shift and the three multiply and sum
// stages, in that order.
// Reset (rst, synchronous) clears the control state and the registers to their
// defaults; the line store needs no clearing pass because rows before the
// frame are masked as border. A stalled result holds in the output register
// while the earlier stages keep filling; pixel_stall rises only when every
// stage is occupied.

module rgb_conv2d_5x5_clamped #(
  parameter int unsigned MAX_WIDTH = rgbc_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pixel_valid,
  output logic                                pixel_stall,
  input  logic                                command,
  input  logic [rgbc_pkg::PIX_W-1:0]          red_in,
  input  logic [rgbc_pkg::PIX_W-1:0]          green_in,
  input  logic [rgbc_pkg::PIX_W-1:0]          blue_in,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [rgbc_pkg::PIX_W-1:0]          red_out,
  output logic [rgbc_pkg::PIX_W-1:0]          green_out,
  output logic [rgbc_pkg::PIX_W-1:0]          blue_out,
  output logic                                frame_last,
  input  logic                                cfg_write,
  input  logic [rgbc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rgbc_pkg::COEF_ROW_W-1:0]     cfg_data
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  // Configuration registers. Mask rows take effect on the next product stage.
  logic [rgbc_pkg::TAPS-1:0][rgbc_pkg::COEF_ROW_W-1:0] coef;
  logic [rgbc_pkg::IMG_W_W-1:0]                        image_width;
  logic [rgbc_pkg::IMG_H_W-1:0]                        image_height;

  logic                                        accept;
  logic                                        keep;
  logic [CW-1:0]                               addr;
  rgbc_pkg::rgb_t                              pix_in;
  rgbc_pkg::rgb_t                              pix_store;
  rgbc_pkg::item_ctl_t                         ctl;
  logic                                        win_ready;
  logic                                        win_valid;
  rgbc_pkg::rgb_t [rgbc_pkg::NTAP-1:0]         win;
  logic                                        win_last;
  logic                                        mac_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef[0]      <= rgbc_pkg::COEF_ROW_RST;
      coef[1]      <= rgbc_pkg::COEF_ROW_RST;
      coef[2]      <= rgbc_pkg::COEF_ROW2_RST;
      coef[3]      <= rgbc_pkg::COEF_ROW_RST;
      coef[4]      <= rgbc_pkg::COEF_ROW_RST;
      image_width  <= rgbc_pkg::IMG_W_RST;
      image_height <= rgbc_pkg::IMG_H_RST;
    end else if (cfg_write) begin
      case (rgbc_pkg::reg_idx_t'(cfg_index))
        rgbc_pkg::REG_COEF0: begin
          coef[0] <= cfg_data;
        end
        rgbc_pkg::REG_COEF1: begin
          coef[1] <= cfg_data;
        end
        rgbc_pkg::REG_COEF2: begin
          coef[2] <= cfg_data;
        end
        rgbc_pkg::REG_COEF3: begin
          coef[3] <= cfg_data;
        end
        rgbc_pkg::REG_COEF4: begin
          coef[4] <= cfg_data;
        end
        rgbc_pkg::REG_WIDTH: begin
          image_width <= cfg_data[rgbc_pkg::IMG_W_W-1:0];
        end
        rgbc_pkg::REG_HEIGHT: begin
          image_height <= cfg_data[rgbc_pkg::IMG_H_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // A pixel transaction completes whenever the column stage can take it. Drain
  // transactions while no frame is active are accepted and dropped.
  assign pixel_stall = !win_ready;
  assign accept      = pixel_valid && !pixel_stall;
  assign pix_in      = '{r: red_in, g: green_in, b: blue_in};

  rgbc_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .command      (command),
    .pix          (pix_in),
    .image_width  (image_width),
    .image_height (image_height),
    .keep         (keep),
    .addr         (addr),
    .pix_store    (pix_store),
    .ctl          (ctl)
  );

  // Every kept transaction shifts a column into the window; only those that
  // complete an output window move on to the arithmetic.
  rgbc_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept && keep),
    .addr       (addr),
    .pix        (pix_store),
    .ctl        (ctl),
    .next_ready (mac_ready),
    .ready      (win_ready),
    .win_valid  (win_valid),
    .win        (win),
    .win_last   (win_last)
  );

  rgbc_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (win_valid),
    .win       (win),
    .in_last   (win_last),
    .coef      (coef),
    .stall     (result_stall),
    .in_ready  (mac_ready),
    .out_valid (result_valid),
    .red       (red_out),
    .green     (green_out),
    .blue      (blue_out),
    .last      (frame_last)
  );

endmodule

FILE: rtl/core/rgbc_checker.sv
// Port-level checks for the 5x5 RGB convolution top level, and the bind that
// attaches them. Depends on rgbc_pkg and rgb_conv2d_5x5_clamped.

module rgbc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       pixel_stall,
  input logic                       result_valid,
  input logic                       result_stall,
  input logic [rgbc_pkg::PIX_W-1:0] red_out,
  input logic [rgbc_pkg::PIX_W-1:0] green_out,
  input logic [rgbc_pkg::PIX_W-1:0] blue_out,
  input logic                       frame_last
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid set right after reset");

  // With the result register empty, nothing downstream can hold the input back.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !pixel_stall)
    else $error("pixel_stall raised while the pipeline can drain");

  // A stalled result stays and keeps its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(red_out)
      && $stable(green_out) && $stable(blue_out) && $stable(frame_last))
    else $error("stalled result changed");

endmodule

bind rgb_conv2d_5x5_clamped rgbc_checker u_rgbc_checker (
  .clk          (clk),
  .rst          (rst),
  .pixel_stall  (pixel_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .red_out      (red_out),
  .green_out    (green_out),
  .blue_out     (blue_out),
  .frame_last   (frame_last)
);
